>>> design/unicycle_heading_speed_controller_top_macros.svh
// assertion macros used by the control law rtl
`ifndef UNICYCLE_HEADING_SPEED_CONTROLLER_TOP_MACROS_SVH
`define UNICYCLE_HEADING_SPEED_CONTROLLER_TOP_MACROS_SVH

// condition now implies a consequence after the delay given by n
`define UHSC_ASSERT_AFTER(label, clk, rst, cond, n, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (conseq)) \
      else $error("controller check failed");

// condition now implies a consequence in the same cycle
`define UHSC_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("controller check failed");

`endif

>>> design/uhsc_pkg.sv
// shared types, constants and tables of the heading and speed controller
package uhsc_pkg;

   // datapath widths
   localparam int X_W        = 35;   // cordic x and y, signed
   localparam int Z_W        = 28;   // cordic angle, 2^-24 rad, signed
   localparam int E_W        = 29;   // turn error before rounding, signed
   localparam int MAG_W      = 26;   // magnitude, Q14.12 unsigned
   localparam int PRESCALE   = 8;
   localparam int MAG_SHIFT  = 16 + PRESCALE;
   localparam int ATAN_DEPTH = 24;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [Z_W-1:0] ANG_HALF_PI = 28'sd26353589;
   localparam logic signed [E_W-1:0] ANG_PI      = 29'sd52707179;
   localparam logic signed [E_W-1:0] ANG_TWO_PI  = 29'sd105414357;
   localparam logic [15:0]           INV_GAIN    = 16'd39796;

   // atan(2^-i) in units of 2^-24 rad
   localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536,   28'sd32768,
      28'sd16384,    28'sd8192,    28'sd4096,    28'sd2048,    28'sd1024,
      28'sd512,      28'sd256,     28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINEAR_GAIN         = 3'd0,
      REG_ANGULAR_GAIN        = 3'd1,
      REG_LINEAR_MAX          = 3'd2,
      REG_ANGULAR_MAX         = 3'd3,
      REG_TURN_STOP_THRESHOLD = 3'd4,
      REG_ANGULAR_MIN_STOPPED = 3'd5,
      REG_ANGULAR_MIN_MOVING  = 3'd6,
      REG_LINEAR_MIN          = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [14:0] linear_max;
      logic [14:0] angular_max;
      logic [14:0] turn_stop_threshold;
      logic [14:0] angular_min_stopped;
      logic [14:0] angular_min_moving;
      logic [14:0] linear_min;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      linear_gain:         16'd625,
      angular_gain:        16'd1249,
      linear_max:          15'd2048,
      angular_max:         15'd12288,
      turn_stop_threshold: 15'd205,
      angular_min_stopped: 15'd4096,
      angular_min_moving:  15'd2458,
      linear_min:          15'd0
   };

   // word handed from cell to cell
   typedef struct packed {
      logic                  zero;
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [Z_W-1:0] z;
      logic [14:0]           heading;
   } cordic_word_type;

endpackage

>>> design/uhsc_cordic_cell.sv
// one vectoring cordic cell: a micro-rotation and its pipeline register
module uhsc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  uhsc_pkg::cordic_word_type in_word,
   output logic                      out_valid,
   output uhsc_pkg::cordic_word_type out_word
);
   import uhsc_pkg::*;

   cordic_word_type       word_in, word_ff;
   logic                  valid_ff;
   logic signed [X_W-1:0] dx, dy;

   always_comb begin
      dx = in_word.y >>> STAGE;
      dy = in_word.x >>> STAGE;
      word_in = in_word;
      if (in_word.y > 0) begin
         word_in.x = in_word.x + dx;
         word_in.y = in_word.y - dy;
         word_in.z = in_word.z + ATAN_TAB[STAGE];
      end else begin
         word_in.x = in_word.x - dx;
         word_in.y = in_word.y + dy;
         word_in.z = in_word.z - ATAN_TAB[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> design/uhsc_law.sv
// control law pipeline: magnitude, error wrap, speed gains and saturation
`include "unicycle_heading_speed_controller_top_macros.svh"

module uhsc_law (
   input  logic                      clock,
   input  logic                      reset,
   input  uhsc_pkg::cfg_type         cfg,
   input  logic                      in_valid,
   input  uhsc_pkg::cordic_word_type in_word,
   output logic                      out_strobe,
   output logic [14:0]               out_linear_speed,
   output logic signed [15:0]        out_angular_speed
);
   import uhsc_pkg::*;

   localparam int STAGES = 7;
   localparam int PROD_W = X_W - 1 + 16;
   localparam int LP_W   = 16 + MAG_W;
   localparam int LS_W   = LP_W - 12 + 1;
   localparam int AP_W   = 31;
   localparam int AS_W   = AP_W - 12 + 1;

   function automatic logic signed [E_W-1:0] wrap_step(input logic signed [E_W-1:0] e);
      if (e < -ANG_PI) begin
         return e + ANG_TWO_PI;
      end else if (e >= ANG_PI) begin
         return e - ANG_TWO_PI;
      end
      return e;
   endfunction

   logic [STAGES-1:0] valid_in, valid_ff;

   // stage a
   logic [PROD_W-1:0]     prod_a_in, prod_a_ff;
   logic                  mag_ok_a_in, mag_ok_a_ff;
   logic signed [E_W-1:0] err_a_in, err_a_ff;
   logic signed [Z_W-1:0] z_use;
   // stage b
   logic [MAG_W-1:0]      mag_b_in, mag_b_ff;
   logic signed [E_W-1:0] err_b_in, err_b_ff;
   // stage c
   logic [LP_W-1:0]       linprod_c_in, linprod_c_ff;
   logic signed [E_W-1:0] err_c_in, err_c_ff;
   // stage d
   logic [LS_W-1:0]       linsum_d_in, linsum_d_ff;
   logic signed [15:0]    err12_d_in, err12_d_ff;
   logic signed [E_W:0]   err_round;
   // stage e
   logic [14:0]           lin_e_in, lin_e_ff;
   logic [14:0]           aerr_e_in, aerr_e_ff;
   logic                  neg_e_in, neg_e_ff;
   logic                  ezero_e_in, ezero_e_ff;
   logic                  stop;
   logic [15:0]           err_neg;
   // stage f
   logic [AP_W-1:0]       aprod_f_in, aprod_f_ff;
   logic [14:0]           offset_f_in, offset_f_ff;
   logic [14:0]           lin_f_in, lin_f_ff;
   logic                  neg_f_in, neg_f_ff;
   logic                  ezero_f_in, ezero_f_ff;
   // stage g
   logic [14:0]           linear_g_in, linear_g_ff;
   logic signed [15:0]    angular_g_in, angular_g_ff;
   logic [AS_W-1:0]       tsum;
   logic [14:0]           tcap;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      // a: magnitude product and raw turn error
      mag_ok_a_in = !in_word.zero && (in_word.x > 0);
      prod_a_in   = PROD_W'(in_word.x[X_W-2:0]) * PROD_W'(INV_GAIN);
      z_use       = in_word.zero ? '0 : in_word.z;
      err_a_in    = E_W'(z_use) - signed'(E_W'({in_word.heading, 12'd0}));
      // b: round magnitude, first wrap
      mag_b_in = mag_ok_a_ff
               ? MAG_W'((prod_a_ff + (PROD_W'(1) << (MAG_SHIFT - 1))) >> MAG_SHIFT)
               : '0;
      err_b_in = wrap_step(err_a_ff);
      // c: linear gain, second wrap
      linprod_c_in = LP_W'(cfg.linear_gain) * LP_W'(mag_b_ff);
      err_c_in     = wrap_step(err_b_ff);
      // d: base speed add, round error to q3.12
      linsum_d_in = LS_W'(cfg.linear_min) + LS_W'(linprod_c_ff >> 12);
      err_round   = (E_W+1)'(err_c_ff) + (E_W+1)'(2048);
      err12_d_in  = 16'(err_round >>> 12);
      // e: cap, and stop when the turn error is above the stop threshold
      stop       = $signed({err12_d_ff[15], err12_d_ff})
                 > $signed({2'b00, cfg.turn_stop_threshold});
      lin_e_in   = (linsum_d_ff > LS_W'(cfg.linear_max)) ? cfg.linear_max
                                                         : linsum_d_ff[14:0];
      if (stop) begin
         lin_e_in = '0;
      end
      err_neg    = 16'(-err12_d_ff);
      neg_e_in   = err12_d_ff[15];
      aerr_e_in  = neg_e_in ? err_neg[14:0] : err12_d_ff[14:0];
      ezero_e_in = (err12_d_ff == '0);
      // f: angular gain, pick offset
      aprod_f_in  = AP_W'(cfg.angular_gain) * AP_W'(aerr_e_ff);
      offset_f_in = (lin_e_ff == '0) ? cfg.angular_min_stopped : cfg.angular_min_moving;
      lin_f_in    = lin_e_ff;
      neg_f_in    = neg_e_ff;
      ezero_f_in  = ezero_e_ff;
      // g: offset add, saturate, apply sign
      tsum = AS_W'(aprod_f_ff >> 12) + AS_W'(offset_f_ff);
      tcap = (tsum > AS_W'(cfg.angular_max)) ? cfg.angular_max : tsum[14:0];
      if (ezero_f_ff) begin
         angular_g_in = '0;
      end else if (neg_f_ff) begin
         angular_g_in = -$signed({1'b0, tcap});
      end else begin
         angular_g_in = $signed({1'b0, tcap});
      end
      linear_g_in = lin_f_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff    <= prod_a_in;
      mag_ok_a_ff  <= mag_ok_a_in;
      err_a_ff     <= err_a_in;
      mag_b_ff     <= mag_b_in;
      err_b_ff     <= err_b_in;
      linprod_c_ff <= linprod_c_in;
      err_c_ff     <= err_c_in;
      linsum_d_ff  <= linsum_d_in;
      err12_d_ff   <= err12_d_in;
      lin_e_ff     <= lin_e_in;
      aerr_e_ff    <= aerr_e_in;
      neg_e_ff     <= neg_e_in;
      ezero_e_ff   <= ezero_e_in;
      aprod_f_ff   <= aprod_f_in;
      offset_f_ff  <= offset_f_in;
      lin_f_ff     <= lin_f_in;
      neg_f_ff     <= neg_f_in;
      ezero_f_ff   <= ezero_f_in;
      linear_g_ff  <= linear_g_in;
      angular_g_ff <= angular_g_in;
   end

   assign out_strobe        = valid_ff[STAGES-1];
   assign out_linear_speed  = linear_g_ff;
   assign out_angular_speed = angular_g_ff;

   // zero error leaves no turn command at the output
   `UHSC_ASSERT_AFTER(a_zero_err_no_turn, clock, reset, valid_ff[4] && ezero_e_ff, 2, out_strobe && out_angular_speed == 0)
   // a stopped robot stays stopped at the output
   `UHSC_ASSERT_AFTER(a_stop_kept, clock, reset, valid_ff[4] && lin_e_ff == 0, 2, out_strobe && out_linear_speed == 0)
   // turn direction follows the sign of the error
   `UHSC_ASSERT_AFTER(a_neg_turn, clock, reset, valid_ff[4] && neg_e_ff, 2, out_angular_speed[15] || out_angular_speed == 0)
   `UHSC_ASSERT_AFTER(a_pos_turn, clock, reset, valid_ff[4] && !neg_e_ff, 2, !out_angular_speed[15])

endmodule

>>> design/unicycle_heading_speed_controller_top.sv
// top level of the unicycle heading and speed controller
//
// one command word (wanted velocity vector and current heading) is taken on
// every clock in which start is high; busy is always low, so a word can be
// issued every cycle. each word gives exactly one result word, shown for one
// cycle with rsp_strobe high. a command passes one input register with the
// quadrant pre-rotation, one cordic cell per stage, and a seven stage control
// law pipeline. results leave in the order the commands came in and cannot be
// held off by the receiver, so the word must be captured in the cycle
// rsp_strobe is high. the csr_ registers are written in one cycle with csr_we
// and should only change while no command is in flight.
module unicycle_heading_speed_controller_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // command side
   input  logic                               start,
   output logic                               busy,
   input  logic signed [23:0]                 req_vel_x,
   input  logic signed [23:0]                 req_vel_y,
   input  logic [14:0]                        req_heading,
   // register write port
   input  logic                               csr_we,
   input  logic [uhsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [15:0]                        csr_wdata,
   // result side
   output logic                               rsp_strobe,
   output logic [14:0]                        rsp_linear_speed,
   output logic signed [15:0]                 rsp_angular_speed
);
   import uhsc_pkg::*;

   // configuration registers
   cfg_type cfg_in, cfg_ff;

   // input register with pre-rotation
   cordic_word_type       pre_in, pre_ff;
   logic                  pre_valid_ff;
   logic signed [X_W-1:0] xs, ys;

   // cell chain
   cordic_word_type       words [CORDIC_STAGES+1];
   logic                  valids [CORDIC_STAGES+1];

   // the pipeline never stalls
   assign busy = 1'b0;

   // register writes, values masked to their widths
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_LINEAR_GAIN:         cfg_in.linear_gain         = csr_wdata;
            REG_ANGULAR_GAIN:        cfg_in.angular_gain        = csr_wdata;
            REG_LINEAR_MAX:          cfg_in.linear_max          = csr_wdata[14:0];
            REG_ANGULAR_MAX:         cfg_in.angular_max         = csr_wdata[14:0];
            REG_TURN_STOP_THRESHOLD: cfg_in.turn_stop_threshold = csr_wdata[14:0];
            REG_ANGULAR_MIN_STOPPED: cfg_in.angular_min_stopped = csr_wdata[14:0];
            REG_ANGULAR_MIN_MOVING:  cfg_in.angular_min_moving  = csr_wdata[14:0];
            REG_LINEAR_MIN:          cfg_in.linear_min          = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scale by 2^8, then move a left half-plane vector into the right half
   // with a quarter turn so the cordic converges over the full circle
   always_comb begin
      xs = X_W'(req_vel_x) <<< PRESCALE;
      ys = X_W'(req_vel_y) <<< PRESCALE;
      pre_in.zero    = (req_vel_x == '0) && (req_vel_y == '0);
      pre_in.heading = req_heading;
      pre_in.x       = xs;
      pre_in.y       = ys;
      pre_in.z       = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            pre_in.x = ys;
            pre_in.y = -xs;
            pre_in.z = ANG_HALF_PI;
         end else begin
            pre_in.x = -ys;
            pre_in.y = xs;
            pre_in.z = -ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign words[0]  = pre_ff;
   assign valids[0] = pre_valid_ff;

   // one cell per cordic stage, each handing its word to the next every clock
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      uhsc_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valids[g]),
         .in_word   (words[g]),
         .out_valid (valids[g+1]),
         .out_word  (words[g+1])
      );
   end

   // magnitude, error wrap and the speed law
   uhsc_law u_law (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .in_valid          (valids[CORDIC_STAGES]),
      .in_word           (words[CORDIC_STAGES]),
      .out_strobe        (rsp_strobe),
      .out_linear_speed  (rsp_linear_speed),
      .out_angular_speed (rsp_angular_speed)
   );

endmodule
